[src/int4mv_pkg.sv]
// shared types and constants for the int4 matrix-vector row scale unit
// no dependencies; imported by the controller, datapath and top level
package int4mv_pkg;

	// fixed field widths
	localparam int VALUE_W = 46;
	localparam int INDEX_W = 11;
	localparam int CFG_W   = 12;
	localparam int SCALE_W = 16;
	localparam int ACTIN_W = 16;
	localparam int BYTE_W  = 8;
	localparam int CIDX_W  = 1;

	// row count limit and register reset values
	localparam logic [CFG_W-1:0] ROW_LIMIT  = 12'd2048;
	localparam logic [CFG_W-1:0] COLS_RESET = 12'd2048;
	localparam logic [CFG_W-1:0] ROWS_RESET = 12'd512;

	// opcodes of an input beat
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_WEIGHT = 1'b1;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_COLS = 1'b0;
	localparam logic [CIDX_W-1:0] REG_ROWS = 1'b1;

	// commands from controller to datapath
	typedef struct packed {
		logic load;   // write one activation
		logic take;   // latch weight byte and scale, read activation pair
		logic mac;    // accumulate the pair products
		logic emit;   // scale the finished row into the output register
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic row_end;   // current pair is the last of the row
		logic out_free;  // output register can take a new result
	} sts_t;

endpackage

[src/int4mv_ctrl.sv]
// controller state machine for the int4 matrix-vector row scale unit
// depends on int4mv_pkg; drives the datapath through cmd_t, reads sts_t
module int4mv_ctrl
	import int4mv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic opcode,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MAC  = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (opcode == OP_LOAD) begin
						cmd.load = 1'b1;
					end else begin
						cmd.take = 1'b1;
						state_d  = S_MAC;
					end
				end
			end
			S_MAC: begin
				cmd.mac = 1'b1;
				state_d = sts.row_end ? S_EMIT : S_IDLE;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a mac cycle always follows an accepted weight beat
	a_mac_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MAC |-> $past(in_valid && in_ready && opcode == OP_WEIGHT))
		else $error("mac cycle without a preceding weight beat");

	// a result is only written into a free output register
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("emit while output register is full");

	// emit state is entered only from the mac of a row end
	a_emit_entry: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_EMIT) |-> $past(state_q == S_MAC && sts.row_end))
		else $error("emit state entered without a row end");

	// no input beat is taken while a row result waits to be emitted
	a_no_accept_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> !in_ready)
		else $error("input accepted during emit");

endmodule

[src/int4mv_datapath.sv]
// datapath for the int4 matrix-vector row scale unit: activation memory,
// pair multiply-accumulate, row scaling and output register
// depends on int4mv_pkg; controlled by int4mv_ctrl
module int4mv_datapath
	import int4mv_pkg::*;
#(
	parameter int MAX_COLS = 2048,
	parameter int ACT_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  logic                      cfg_we,
	input  logic [CIDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic [INDEX_W-1:0]        act_index,
	input  logic signed [ACTIN_W-1:0] act_value,
	input  logic [BYTE_W-1:0]         weight_byte,
	input  logic signed [SCALE_W-1:0] row_scale,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic signed [VALUE_W-1:0] row_value,
	output logic [INDEX_W-1:0]        row_index,
	output logic                      last_row
);

	localparam int ADDR_W = $clog2(MAX_COLS);
	localparam int SUM_W  = ACT_BITS + 4 + $clog2(MAX_COLS);
	localparam int PROD_W = SUM_W + SCALE_W;
	localparam logic [16:0] MAX_COLS_V = 17'(MAX_COLS);

	// configuration registers
	logic [CFG_W-1:0] cols_q;
	logic [CFG_W-1:0] rows_q;

	// row state
	logic [ADDR_W-1:0]       pair_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [INDEX_W-1:0]      row_count_q;

	// latched weight beat and memory read data
	logic [BYTE_W-1:0]         wb_q;
	logic signed [SCALE_W-1:0] scale_q;
	logic [ACT_BITS-1:0]       rd_even_q;
	logic [ACT_BITS-1:0]       rd_odd_q;
	logic signed [SUM_W-1:0]   fin_q;
	logic                      fin_last_q;

	// output register
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] row_value_q;
	logic [INDEX_W-1:0]        row_index_q;
	logic                      last_row_q;

	logic [ACT_BITS-1:0] mem [MAX_COLS];

	logic                      wr_en;
	logic [ADDR_W-1:0]         wr_addr;
	logic [ADDR_W-1:0]         even_addr;
	logic [ADDR_W-1:0]         odd_addr;
	logic [16:0]               cols_even;
	logic [16:0]               cols_clamp;
	logic [16:0]               last_pair;
	logic [CFG_W-1:0]          rows_clamp;
	logic [CFG_W-1:0]          last_row_idx;
	logic                      row_end;
	logic                      row_last;
	logic signed [3:0]         nib_lo;
	logic signed [3:0]         nib_hi;
	logic signed [ACT_BITS+3:0] prod_lo;
	logic signed [ACT_BITS+3:0] prod_hi;
	logic signed [ACT_BITS+4:0] pair_sum;
	logic signed [SUM_W-1:0]   new_sum;
	logic signed [PROD_W-1:0]  scaled;

	// memory addressing
	assign wr_en     = cmd.load && (32'(act_index) < MAX_COLS);
	assign wr_addr   = ADDR_W'(act_index);
	assign even_addr = ADDR_W'({pair_q, 1'b0});
	assign odd_addr  = ADDR_W'({pair_q, 1'b1});

	// last pair of a row from the clamped column count
	always_comb begin
		cols_even = {5'd0, cols_q[CFG_W-1:1], 1'b0};
		priority if (cols_even < 17'd2) begin
			cols_clamp = 17'd2;
		end else if (cols_even > MAX_COLS_V) begin
			cols_clamp = MAX_COLS_V;
		end else begin
			cols_clamp = cols_even;
		end
		last_pair = (cols_clamp >> 1) - 17'd1;
		row_end   = 17'(pair_q) >= last_pair;
	end

	// last row of a matrix from the clamped row count
	always_comb begin
		priority if (rows_q == '0) begin
			rows_clamp = 12'd1;
		end else if (rows_q > ROW_LIMIT) begin
			rows_clamp = ROW_LIMIT;
		end else begin
			rows_clamp = rows_q;
		end
		last_row_idx = rows_clamp - 12'd1;
		row_last     = {1'b0, row_count_q} >= last_row_idx;
	end

	// signed nibble products and pair sum
	always_comb begin
		nib_lo   = $signed(wb_q[3:0]);
		nib_hi   = $signed(wb_q[7:4]);
		prod_lo  = $signed(rd_even_q) * nib_lo;
		prod_hi  = $signed(rd_odd_q) * nib_hi;
		pair_sum = prod_lo + prod_hi;
		new_sum  = sum_q + SUM_W'(pair_sum);
		scaled   = fin_q * scale_q;
	end

	// activation memory, registered reads of the even and odd column
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= ACT_BITS'($unsigned(act_value));
		end
		rd_even_q <= mem[even_addr];
		rd_odd_q  <= mem[odd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			wb_q    <= weight_byte;
			scale_q <= row_scale;
		end
		if (cmd.mac && row_end) begin
			fin_q <= new_sum;
		end
		if (cmd.emit) begin
			row_value_q <= VALUE_W'(scaled);
			row_index_q <= row_count_q;
			last_row_q  <= fin_last_q;
		end
	end

	// configuration, row state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q      <= COLS_RESET;
			rows_q      <= ROWS_RESET;
			pair_q      <= '0;
			sum_q       <= '0;
			row_count_q <= '0;
			fin_last_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_COLS: cols_q <= cfg_data;
					REG_ROWS: rows_q <= cfg_data;
				endcase
			end
			if (cmd.mac) begin
				if (row_end) begin
					pair_q     <= '0;
					sum_q      <= '0;
					fin_last_q <= row_last;
				end else begin
					pair_q <= pair_q + 1'b1;
					sum_q  <= new_sum;
				end
			end
			if (cmd.emit) begin
				row_count_q <= fin_last_q ? '0 : row_count_q + 1'b1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.row_end  = row_end;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign row_value = row_value_q;
	assign row_index = row_index_q;
	assign last_row  = last_row_q;

endmodule

[src/int4_matvec_row_scale_unit.sv]
// top level of the int4 matrix-vector row scale unit
// depends on int4mv_pkg, int4mv_ctrl and int4mv_datapath
//
//   channel  handshake              payload
//   in       in_valid / in_ready    opcode, act_index, act_value, weight_byte, row_scale
//   out      out_valid / out_ready  row_value, row_index, last_row
//   cfg      cfg_we                 cfg_index, cfg_data
//
// a load beat is accepted in the idle state; a weight beat is accepted, then
// multiply-accumulated after the registered activation memory read
// a row's last weight beat also passes through the emit state for the
// row scale multiply, held while the output register is still full
// reset clears the row state and output valid; the activation memory is not cleared
// the output register lets new beats be accepted while a result waits
module int4_matvec_row_scale_unit
	import int4mv_pkg::*;
#(
	parameter int MAX_COLS = 2048,
	parameter int ACT_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      opcode,
	input  logic [INDEX_W-1:0]        act_index,
	input  logic signed [ACTIN_W-1:0] act_value,
	input  logic [BYTE_W-1:0]         weight_byte,
	input  logic signed [SCALE_W-1:0] row_scale,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [VALUE_W-1:0] row_value,
	output logic [INDEX_W-1:0]        row_index,
	output logic                      last_row,
	input  logic                      cfg_we,
	input  logic [CIDX_W-1:0]         cfg_index,
	input  logic [CFG_W-1:0]          cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// control
	int4mv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	int4mv_datapath #(
		.MAX_COLS (MAX_COLS),
		.ACT_BITS (ACT_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.act_index   (act_index),
		.act_value   (act_value),
		.weight_byte (weight_byte),
		.row_scale   (row_scale),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.row_value   (row_value),
		.row_index   (row_index),
		.last_row    (last_row)
	);

endmodule
